// ===== rtl/core/aaf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aaf_pkg: shared types and codes of the accumulator ALU
// Opcode fields, ALU operation and condition codes, and the structs that
// carry architectural state and one instruction's outcome between modules.
// ----------------------------------------------------------------------------
package aaf_pkg;

    // Operation field (bits 5..3) of the ALU group and immediate group.
    typedef enum logic [2:0] {
        ALU_ADD = 3'd0,
        ALU_ADC = 3'd1,
        ALU_SUB = 3'd2,
        ALU_SBB = 3'd3,
        ALU_ANA = 3'd4,
        ALU_XRA = 3'd5,
        ALU_ORA = 3'd6,
        ALU_CMP = 3'd7
    } t_alu_op;

    // Condition field (bits 5..3) evaluated on the flags before the instruction.
    typedef enum logic [2:0] {
        COND_NZ = 3'd0,
        COND_Z  = 3'd1,
        COND_NC = 3'd2,
        COND_C  = 3'd3,
        COND_PO = 3'd4,
        COND_PE = 3'd5,
        COND_P  = 3'd6,
        COND_M  = 3'd7
    } t_cond_code;

    // Register field value that selects the accumulator.
    localparam logic [2:0] REG_A = 3'd7;

    // Accumulator-only opcodes.
    localparam logic [7:0] OPC_RLC = 8'h07;
    localparam logic [7:0] OPC_RRC = 8'h0F;
    localparam logic [7:0] OPC_RAL = 8'h17;
    localparam logic [7:0] OPC_RAR = 8'h1F;
    localparam logic [7:0] OPC_CMA = 8'h2F;
    localparam logic [7:0] OPC_STC = 8'h37;
    localparam logic [7:0] OPC_CMC = 8'h3F;

    typedef struct packed {
        logic s;
        logic z;
        logic ac;
        logic p;
        logic cy;
    } t_flags;

    typedef struct packed {
        logic [7:0] acc;
        t_flags     flags;
    } t_state;

    typedef struct packed {
        t_state     next;
        logic [7:0] result;
        logic       cond_met;
        logic       handled;
    } t_alu_result;

endpackage

// ===== rtl/core/accumulator_alu_with_flags.sv =====
`timescale 1ns / 1ps
// An accepted transaction passes through the input register and then the result register.
// Throughput: one instruction per cycle unless stalled; the accumulator and flags update when an
// instruction moves from the input register into the result register, so the next one sees them.
// Backpressure on the result side stalls the input register; one extra item is held there.
// Reset (synchronous, active low) clears A, all flags and both valid bits.
// ----------------------------------------------------------------------------
// accumulator_alu_with_flags: 8080-style accumulator and flag unit
// Input register, single-pass ALU and result register with valid/ready on
// both sides. Keeps the accumulator and the S, Z, AC, P and CY flags.
// ----------------------------------------------------------------------------
module accumulator_alu_with_flags (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_opcode,
    input  logic [7:0] i_operand,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_acc,
    output logic [7:0] o_result_value,
    output logic       o_sign,
    output logic       o_zero,
    output logic       o_aux_carry,
    output logic       o_parity_even,
    output logic       o_carry,
    output logic       o_condition_met,
    output logic       o_handled
);

    logic                 r_in_valid;
    logic [7:0]           r_opcode;
    logic [7:0]           r_operand;
    aaf_pkg::t_state      r_state;
    logic                 r_out_valid;
    aaf_pkg::t_alu_result r_out;
    aaf_pkg::t_alu_result alu_res;
    logic                 advance;
    logic                 in_fire;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_fire    = i_in_valid && o_in_ready;

    aaf_alu u_alu (
        .i_opcode  (r_opcode),
        .i_operand (r_operand),
        .i_state   (r_state),
        .o_res     (alu_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_opcode  <= i_opcode;
            r_operand <= i_operand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= alu_res.next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= alu_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_acc           = r_out.next.acc;
    assign o_result_value  = r_out.result;
    assign o_sign          = r_out.next.flags.s;
    assign o_zero          = r_out.next.flags.z;
    assign o_aux_carry     = r_out.next.flags.ac;
    assign o_parity_even   = r_out.next.flags.p;
    assign o_carry         = r_out.next.flags.cy;
    assign o_condition_met = r_out.cond_met;
    assign o_handled       = r_out.handled;

    // A pending result always reflects the current architectural state.
    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.next == r_state))
        else $error("result register out of step with accumulator and flags");

    // An unhandled opcode must leave A and the flags untouched.
    a_unhandled_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !alu_res.handled) |=> (r_state == $past(r_state)))
        else $error("unhandled opcode changed architectural state");

    // Compare updates flags only.
    a_cmp_keeps_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_opcode[7] && (r_opcode[5:3] == aaf_pkg::ALU_CMP) &&
         (!r_opcode[6] || (r_opcode[2:0] == 3'd6)))
        |=> (r_state.acc == $past(r_state.acc)))
        else $error("compare wrote the accumulator");

    // A stalled instruction stays in the input register.
    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_opcode)))
        else $error("stalled instruction lost from input register");

endmodule

// ===== rtl/core/aaf_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aaf_alu: accumulator and flag logic
// Decodes one opcode and computes the next accumulator, the flags, the ALU
// result and the condition test in a single combinational pass.
// ----------------------------------------------------------------------------
module aaf_alu (
    input  logic [7:0]           i_opcode,
    input  logic [7:0]           i_operand,
    input  aaf_pkg::t_state      i_state,
    output aaf_pkg::t_alu_result o_res
);

    logic [2:0]        mid;
    logic [2:0]        low;
    logic [7:0]        a;
    aaf_pkg::t_flags   fl;
    aaf_pkg::t_alu_op  op;
    logic              is_alu_reg;
    logic              is_alu_imm;
    logic              is_incdec;
    logic              is_sub;
    logic [7:0]        src;
    logic [7:0]        nb;
    logic              cin;
    logic [8:0]        sum9;
    logic [4:0]        nib5;
    logic [7:0]        v;
    logic [7:0]        res;
    logic [7:0]        n_acc;
    aaf_pkg::t_flags   n_flags;
    logic              handled;
    logic              cond;

    assign mid        = i_opcode[5:3];
    assign low        = i_opcode[2:0];
    assign a          = i_state.acc;
    assign fl         = i_state.flags;
    assign op         = aaf_pkg::t_alu_op'(mid);
    assign is_alu_reg = (i_opcode[7:6] == 2'b10);
    assign is_alu_imm = (i_opcode[7:6] == 2'b11) && (low == 3'd6);
    assign is_incdec  = (i_opcode[7:6] == 2'b00) && (i_opcode[2:1] == 2'b10);

    // Subtraction is done as A + ~B + carry in, with CY reported as the borrow.
    assign is_sub = (op == aaf_pkg::ALU_SUB) || (op == aaf_pkg::ALU_SBB) ||
                    (op == aaf_pkg::ALU_CMP);
    assign src    = (is_alu_reg && (low == aaf_pkg::REG_A)) ? a : i_operand;
    assign nb     = is_sub ? ~src : src;
    assign sum9   = {1'b0, a} + {1'b0, nb} + {8'b0, cin};
    assign nib5   = {1'b0, a[3:0]} + {1'b0, nb[3:0]} + {4'b0, cin};
    assign v      = (mid == aaf_pkg::REG_A) ? a : i_operand;

    always_comb begin
        case (op)
            aaf_pkg::ALU_ADC: cin = fl.cy;
            aaf_pkg::ALU_SUB: cin = 1'b1;
            aaf_pkg::ALU_SBB: cin = ~fl.cy;
            aaf_pkg::ALU_CMP: cin = 1'b1;
            default:          cin = 1'b0;
        endcase
    end

    always_comb begin
        case (aaf_pkg::t_cond_code'(mid))
            aaf_pkg::COND_NZ: cond = ~fl.z;
            aaf_pkg::COND_Z:  cond = fl.z;
            aaf_pkg::COND_NC: cond = ~fl.cy;
            aaf_pkg::COND_C:  cond = fl.cy;
            aaf_pkg::COND_PO: cond = ~fl.p;
            aaf_pkg::COND_PE: cond = fl.p;
            aaf_pkg::COND_P:  cond = ~fl.s;
            aaf_pkg::COND_M:  cond = fl.s;
            default:          cond = 1'b0;
        endcase
    end

    always_comb begin
        n_acc   = a;
        n_flags = fl;
        res     = 8'h00;
        handled = 1'b1;
        if (is_alu_reg || is_alu_imm) begin
            case (op)
                aaf_pkg::ALU_ADD, aaf_pkg::ALU_ADC: begin
                    res        = sum9[7:0];
                    n_flags.ac = nib5[4];
                    n_flags.cy = sum9[8];
                end
                aaf_pkg::ALU_SUB, aaf_pkg::ALU_SBB, aaf_pkg::ALU_CMP: begin
                    res        = sum9[7:0];
                    n_flags.ac = nib5[4];
                    n_flags.cy = ~sum9[8];
                end
                aaf_pkg::ALU_ANA: begin
                    res        = a & src;
                    n_flags.ac = a[3] | src[3];
                    n_flags.cy = 1'b0;
                end
                aaf_pkg::ALU_XRA: begin
                    res        = a ^ src;
                    n_flags.ac = 1'b0;
                    n_flags.cy = 1'b0;
                end
                default: begin
                    res        = a | src;
                    n_flags.ac = 1'b0;
                    n_flags.cy = 1'b0;
                end
            endcase
            n_flags.s = res[7];
            n_flags.z = (res == 8'h00);
            n_flags.p = ~^res;
            if (op != aaf_pkg::ALU_CMP) begin
                n_acc = res;
            end
        end else if (is_incdec) begin
            // Bit 0 of the opcode separates DCR from INR; CY is untouched.
            if (!i_opcode[0]) begin
                res        = v + 8'd1;
                n_flags.ac = (v[3:0] == 4'hF);
            end else begin
                res        = v - 8'd1;
                n_flags.ac = (v[3:0] != 4'h0);
            end
            n_flags.s = res[7];
            n_flags.z = (res == 8'h00);
            n_flags.p = ~^res;
            if (mid == aaf_pkg::REG_A) begin
                n_acc = res;
            end
        end else begin
            case (i_opcode)
                aaf_pkg::OPC_RLC: begin
                    n_flags.cy = a[7];
                    n_acc      = {a[6:0], a[7]};
                end
                aaf_pkg::OPC_RRC: begin
                    n_flags.cy = a[0];
                    n_acc      = {a[0], a[7:1]};
                end
                aaf_pkg::OPC_RAL: begin
                    n_flags.cy = a[7];
                    n_acc      = {a[6:0], fl.cy};
                end
                aaf_pkg::OPC_RAR: begin
                    n_flags.cy = a[0];
                    n_acc      = {fl.cy, a[7:1]};
                end
                aaf_pkg::OPC_CMA: n_acc = ~a;
                aaf_pkg::OPC_STC: n_flags.cy = 1'b1;
                aaf_pkg::OPC_CMC: n_flags.cy = ~fl.cy;
                default:          handled = 1'b0;
            endcase
            res = handled ? n_acc : 8'h00;
        end
    end

    assign o_res.next.acc   = n_acc;
    assign o_res.next.flags = n_flags;
    assign o_res.result     = res;
    assign o_res.cond_met   = cond;
    assign o_res.handled    = handled;

endmodule
